// ===== src/epsm_pkg.sv =====
// Shared widths, register map, reset values and sequencer codes for the
// encoder period speed meter. No dependencies.
package epsm_pkg;

  localparam int WP_W   = 9;
  localparam int TR_W   = 24;
  localparam int PPR_W  = 16;
  localparam int CNT_W  = 8;
  localparam int WRAP_W = 24;
  localparam int OUT_W  = 32;
  localparam int BASE_W = 33;
  localparam int DIVR_W = 48;

  localparam logic [WP_W-1:0]  WP_RST  = 9'd250;
  localparam logic [TR_W-1:0]  TR_RST  = 24'd250000;
  localparam logic [PPR_W-1:0] PPR_RST = 16'd622;

  localparam logic [1:0] REG_WRAP_PERIOD    = 2'd0;
  localparam logic [1:0] REG_TICK_RATE      = 2'd1;
  localparam logic [1:0] REG_PULSES_PER_REV = 2'd2;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_SUB  = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [4:0] MUL1_LAST = 5'd8;
  localparam logic [4:0] MUL2_LAST = 5'd15;
  localparam logic [4:0] DIV_LAST  = 5'd31;

  localparam logic [WRAP_W-1:0] WRAPS_MAX = {WRAP_W{1'b1}};
  localparam logic [OUT_W-1:0]  SAT_MAX   = {OUT_W{1'b1}};

endpackage

// ===== src/encoder_period_speed_meter.sv =====
// Encoder period speed meter: interval from timer wraps and counts, then speed by
// bit-serial multiply and restoring divide. Depends on epsm_pkg.
//
//   channel  direction  payload
//   in_      slave      tuser[0] operation; tdata[7:0] count_value
//   out_     master     tdata[31:0] interval_ticks, [63:32] speed_q8; tuser[0] zero_interval
//   cfg_     APB        0x0 wrap_period, 0x4 tick_rate, 0x8 pulses_per_rev
//
// A tick beat only advances the saturating wrap count. An edge beat holds the datapath
// after its accept: the wraps*wrap_period shift-add, the subtract, the pulses*interval
// shift-add, the restoring divide and the load of the output register run in turn,
// and no new beat is taken until they are done. A zero or negative interval, or a
// zero pulses_per_rev, skips the multiply and divide and goes straight to the output
// load. The output register loads only when it is empty or being drained; otherwise
// the finished result waits and in_tready stays low. rst_n is synchronous and
// active low and restores the register reset values.
module encoder_period_speed_meter
  import epsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] count_value
  input  logic [0:0]  in_tuser,     // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,    // [31:0] interval_ticks, [63:32] speed_q8
  output logic [0:0]  out_tuser,    // [0] zero_interval
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [WP_W-1:0]   wp_r;
  logic [TR_W-1:0]   tr_r;
  logic [PPR_W-1:0]  ppr_r;
  logic [CNT_W-1:0]  prev_r, prev_nxt;
  logic [WRAP_W-1:0] wraps_r, wraps_nxt;
  logic [2:0]        state_r, state_nxt;
  logic [4:0]        step_r, step_nxt;
  logic              ovalid_r, ovalid_nxt;

  logic [CNT_W-1:0]  oprev_r, oprev_nxt;
  logic [DIVR_W-1:0] acc_r, acc_nxt;
  logic [DIVR_W-1:0] mcand_r, mcand_nxt;
  logic [PPR_W-1:0]  mplr_r, mplr_nxt;
  logic [OUT_W-1:0]  rem_r, rem_nxt;
  logic [OUT_W-1:0]  quo_r, quo_nxt;
  logic [OUT_W-1:0]  ivl_r, ivl_nxt;
  logic              zf_r, zf_nxt;
  logic [OUT_W-1:0]  oivl_r, oivl_nxt;
  logic [OUT_W-1:0]  ospd_r, ospd_nxt;
  logic              ozf_r, ozf_nxt;

  logic              in_acc, cfg_wr;
  logic [BASE_W-1:0] diff;
  logic [BASE_W:0]   rem_sh;
  logic              rem_ge;
  logic [BASE_W:0]   rem_sub;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {ospd_r, oivl_r};
  assign out_tuser  = ozf_r;

  always_comb begin
    case (cfg_paddr[3:2])
      REG_WRAP_PERIOD:    cfg_prdata = {{(32-WP_W){1'b0}}, wp_r};
      REG_TICK_RATE:      cfg_prdata = {{(32-TR_W){1'b0}}, tr_r};
      REG_PULSES_PER_REV: cfg_prdata = {{(32-PPR_W){1'b0}}, ppr_r};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  assign diff    = acc_r[BASE_W-1:0] - {{(BASE_W-CNT_W){1'b0}}, oprev_r};
  // One restoring step: the remainder never exceeds the 32-bit dividend.
  assign rem_sh  = {1'b0, rem_r, quo_r[OUT_W-1]};
  assign rem_ge  = {{(DIVR_W-BASE_W){1'b0}}, rem_sh} >= {1'b0, acc_r};
  assign rem_sub = rem_sh - acc_r[BASE_W:0];

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    ovalid_nxt = ovalid_r;
    prev_nxt   = prev_r;
    wraps_nxt  = wraps_r;
    oprev_nxt  = oprev_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplr_nxt   = mplr_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    ivl_nxt    = ivl_r;
    zf_nxt     = zf_r;
    oivl_nxt   = oivl_r;
    ospd_nxt   = ospd_r;
    ozf_nxt    = ozf_r;

    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] == OP_TICK) begin
            if (wraps_r != WRAPS_MAX) begin
              wraps_nxt = wraps_r + 1'b1;
            end
          end else begin
            oprev_nxt = prev_r;
            prev_nxt  = in_tdata[CNT_W-1:0];
            wraps_nxt = '0;
            acc_nxt   = {{(DIVR_W-CNT_W){1'b0}}, in_tdata[CNT_W-1:0]};
            mcand_nxt = {{(DIVR_W-WRAP_W){1'b0}}, wraps_r};
            mplr_nxt  = {{(PPR_W-WP_W){1'b0}}, wp_r};
            step_nxt  = '0;
            state_nxt = ST_MUL1;
          end
        end
      end
      ST_MUL1, ST_MUL2: begin
        if (mplr_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt = {mcand_r[DIVR_W-2:0], 1'b0};
        mplr_nxt  = {1'b0, mplr_r[PPR_W-1:1]};
        step_nxt  = step_r + 1'b1;
        if (state_r == ST_MUL1 && step_r == MUL1_LAST) begin
          state_nxt = ST_SUB;
        end else if (state_r == ST_MUL2 && step_r == MUL2_LAST) begin
          rem_nxt   = '0;
          quo_nxt   = {tr_r, 8'd0};
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_SUB: begin
        if (acc_r[BASE_W-1:0] <= {{(BASE_W-CNT_W){1'b0}}, oprev_r}) begin
          ivl_nxt   = '0;
          quo_nxt   = SAT_MAX;
          zf_nxt    = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          ivl_nxt = diff[BASE_W-1] ? SAT_MAX : diff[OUT_W-1:0];
          zf_nxt  = 1'b0;
          if (ppr_r == '0) begin
            quo_nxt   = SAT_MAX;
            state_nxt = ST_DONE;
          end else begin
            acc_nxt   = '0;
            mcand_nxt = {{(DIVR_W-OUT_W){1'b0}},
                         (diff[BASE_W-1] ? SAT_MAX : diff[OUT_W-1:0])};
            mplr_nxt  = ppr_r;
            step_nxt  = '0;
            state_nxt = ST_MUL2;
          end
        end
      end
      ST_DIV: begin
        rem_nxt  = rem_ge ? rem_sub[OUT_W-1:0] : rem_sh[OUT_W-1:0];
        quo_nxt  = {quo_r[OUT_W-2:0], rem_ge};
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          oivl_nxt   = ivl_r;
          ospd_nxt   = quo_r;
          ozf_nxt    = zf_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      step_r   <= '0;
      ovalid_r <= 1'b0;
      prev_r   <= '0;
      wraps_r  <= '0;
      wp_r     <= WP_RST;
      tr_r     <= TR_RST;
      ppr_r    <= PPR_RST;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      ovalid_r <= ovalid_nxt;
      prev_r   <= prev_nxt;
      wraps_r  <= wraps_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          REG_WRAP_PERIOD:    wp_r  <= cfg_pwdata[WP_W-1:0];
          REG_TICK_RATE:      tr_r  <= cfg_pwdata[TR_W-1:0];
          REG_PULSES_PER_REV: ppr_r <= cfg_pwdata[PPR_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    oprev_r <= oprev_nxt;
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    mplr_r  <= mplr_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    ivl_r   <= ivl_nxt;
    zf_r    <= zf_nxt;
    oivl_r  <= oivl_nxt;
    ospd_r  <= ospd_nxt;
    ozf_r   <= ozf_nxt;
  end

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for encoder_period_speed_meter: a directed table followed by
// random phases, every result beat checked against an in-bench speed predictor or a pinned table value.
// Depends on epsm_pkg and the encoder_period_speed_meter RTL.
module tb;
  import epsm_pkg::*;

  localparam int         DRAIN_CYCLES = 100;
  localparam int         STALL_LIMIT  = 4000;
  localparam int         HOLD_CYCLES  = 600;
  localparam int         PHASES       = 8;
  localparam int         PHASE_ITEMS  = 200;
  localparam logic [1:0] REG_UNUSED   = 2'd3;

  typedef struct packed {
    logic [OUT_W-1:0] interval;
    logic [OUT_W-1:0] speed;
    logic             zero_flag;
  } speed_res_t;

  typedef struct packed {
    bit         pinned;
    speed_res_t res;
  } beat_tag_t;

  typedef enum logic [1:0] {ROW_TICK, ROW_EDGE, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  cnt;
    logic [1:0]  idx;
    logic [31:0] data;
    bit          pinned;
    speed_res_t  res;
  } step_row_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;   // [7:0] count_value
  logic [0:0]  in_tuser    = '0;   // [0] operation
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [63:0] out_tdata;          // [31:0] interval_ticks, [63:32] speed_q8
  logic [0:0]  out_tuser;          // [0] zero_interval
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predictor state, kept in step with accepted beats and register writes.
  logic [WP_W-1:0]   cur_wrap_period = WP_RST;
  logic [TR_W-1:0]   cur_tick_rate   = TR_RST;
  logic [PPR_W-1:0]  cur_pulses      = PPR_RST;
  logic [CNT_W-1:0]  cur_prev_count  = '0;
  logic [WRAP_W-1:0] cur_wraps       = '0;

  speed_res_t expect_q[$];
  beat_tag_t  pin_q[$];
  step_row_t  directed[$];

  int fail_count   = 0;
  int results_seen = 0;
  int n_items      = 0;
  int n_edges      = 0;
  int n_writes     = 0;
  int quiet_cycles = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int phase_wp     = 250;
  bit held         = 1'b0;
  logic [7:0] last_cnt = '0;

  encoder_period_speed_meter u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      fail_count++;
    end
  endfunction

  // Interval and speed for one edge beat; also moves the edge state on.
  function automatic speed_res_t measure_edge(input logic [7:0] cnt);
    logic [63:0] base;
    logic [63:0] span;
    logic [63:0] divisor;
    logic [63:0] quot;
    speed_res_t  r;
    base = 64'(cur_wraps) * 64'(cur_wrap_period) + 64'(cnt);
    if (base <= 64'(cur_prev_count)) begin
      r.interval  = '0;
      r.speed     = SAT_MAX;
      r.zero_flag = 1'b1;
    end else begin
      span = base - 64'(cur_prev_count);
      if (span > 64'(SAT_MAX)) span = 64'(SAT_MAX);
      divisor = 64'(cur_pulses) * span;
      if (divisor == 0) quot = 64'(SAT_MAX);
      else quot = (64'(cur_tick_rate) << 8) / divisor;
      if (quot > 64'(SAT_MAX)) quot = 64'(SAT_MAX);
      r.interval  = span[31:0];
      r.speed     = quot[31:0];
      r.zero_flag = 1'b0;
    end
    cur_prev_count = cnt;
    cur_wraps      = '0;
    return r;
  endfunction

  function automatic step_row_t tick_row();
    step_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    return r;
  endfunction

  function automatic step_row_t edge_row(input logic [7:0] cnt);
    step_row_t r;
    r = '0;
    r.kind = ROW_EDGE;
    r.cnt  = cnt;
    return r;
  endfunction

  function automatic step_row_t pin_row(input logic [7:0] cnt, input logic [31:0] interval,
                                        input logic [31:0] speed, input logic flag);
    step_row_t r;
    r = edge_row(cnt);
    r.pinned = 1'b1;
    r.res    = '{interval, speed, flag};
    return r;
  endfunction

  function automatic step_row_t reg_row(input logic [1:0] idx, input logic [31:0] data);
    step_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return $urandom_range(2);
    if (roll < 90) return $urandom_range(3, 20);
    if (roll < 98) return $urandom_range(20, 100);
    return $urandom_range(300, 800);
  endfunction

  function automatic logic [7:0] pick_count();
    case ($urandom_range(9))
      6, 7: begin
        if (phase_wp > 1) return 8'($urandom_range(phase_wp > 256 ? 255 : phase_wp - 1));
        return 8'($urandom_range(255));
      end
      8: return last_cnt;
      9: return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic apb(input logic wr, input logic [3:0] addr, input logic [31:0] data,
                     output logic [31:0] rd);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every expected result has arrived, then lets the datapath run idle
  // before the caller goes on.
  task automatic settle();
    repeat (2) @(posedge clk);
    while (expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    logic [31:0] mask;
    in_tvalid <= 1'b0;
    settle();
    apb(1'b1, {idx, 2'b00}, value, rd);
    if (idx != REG_UNUSED) begin
      case (idx)
        REG_WRAP_PERIOD: mask = (32'd1 << WP_W) - 1;
        REG_TICK_RATE:   mask = (32'd1 << TR_W) - 1;
        default:         mask = (32'd1 << PPR_W) - 1;
      endcase
      apb(1'b0, {idx, 2'b00}, '0, rd);
      check_field("register readback", value & mask, rd);
    end
  endtask

  task automatic offer(input logic op, input logic [7:0] cnt, input bit pinned,
                       input speed_res_t res);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    pin_q.push_back('{pinned, res});
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= cnt;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Checker and predictor update, sampled at the rising edge.
  always @(posedge clk) begin
    beat_tag_t  tag;
    speed_res_t want;
    bit         moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        results_seen++;
        if (expect_q.size() == 0) begin
          $error("result beat with nothing expected: interval 0x%08h speed 0x%08h",
                 out_tdata[31:0], out_tdata[63:32]);
          fail_count++;
        end else begin
          want = expect_q.pop_front();
          check_field("interval_ticks", want.interval, out_tdata[31:0]);
          check_field("speed_q8", want.speed, out_tdata[63:32]);
          check_field("zero_interval", 32'(want.zero_flag), 32'(out_tuser[0]));
        end
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        n_items++;
        tag = pin_q.pop_front();
        if (in_tuser[0] == OP_EDGE) begin
          n_edges++;
          want = measure_edge(in_tdata);
          expect_q.push_back(tag.pinned ? tag.res : want);
        end else if (cur_wraps != WRAPS_MAX) begin
          cur_wraps++;
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        moved = 1'b1;
        n_writes++;
        case (cfg_paddr[3:2])
          REG_WRAP_PERIOD:    cur_wrap_period = cfg_pwdata[WP_W-1:0];
          REG_TICK_RATE:      cur_tick_rate   = cfg_pwdata[TR_W-1:0];
          REG_PULSES_PER_REV: cur_pulses      = cfg_pwdata[PPR_W-1:0];
          default: ;
        endcase
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off so the input backs up.
  initial begin : sink
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!held && results_seen >= 60) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    step_row_t   row;
    logic [31:0] data;
    logic [7:0]  cnt;
    int          gap;
    int          sent;
    int          wp;
    int          rate;
    int          ppr;
    directed = {
      pin_row(8'd0, 32'd0, SAT_MAX, 1'b1),     // first edge after reset: nothing elapsed
      edge_row(8'd255),
      tick_row(), tick_row(),
      edge_row(8'd10),
      pin_row(8'd10, 32'd0, SAT_MAX, 1'b1),    // same count again
      pin_row(8'd5, 32'd0, SAT_MAX, 1'b1),     // count went backwards
      reg_row(REG_WRAP_PERIOD, 32'd0),
      tick_row(), tick_row(),
      edge_row(8'd200),                        // wraps count for nothing now
      reg_row(REG_PULSES_PER_REV, 32'd0),
      pin_row(8'd255, 32'd55, SAT_MAX, 1'b0),  // zero divisor
      reg_row(REG_WRAP_PERIOD, 32'd256),
      reg_row(REG_TICK_RATE, 32'h00FF_FFFF),
      reg_row(REG_PULSES_PER_REV, 32'h0000_FFFF),
      tick_row(),
      edge_row(8'd0),
      reg_row(REG_UNUSED, 32'hFFFF_FFFF),      // must leave every register alone
      edge_row(8'd1),
      reg_row(REG_TICK_RATE, 32'd1),
      reg_row(REG_PULSES_PER_REV, 32'd1),
      reg_row(REG_WRAP_PERIOD, 32'h1FF),       // counts may now exceed nothing, wrap is wide
      tick_row(),
      edge_row(8'd255),
      pin_row(8'd255, 32'd0, SAT_MAX, 1'b1),
      tick_row(),
      edge_row(8'd0)
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      row = directed[i];
      case (row.kind)
        ROW_REG:  write_reg(row.idx, row.data);
        ROW_TICK: offer(OP_TICK, row.cnt, 1'b0, '0);
        default:  offer(OP_EDGE, row.cnt, row.pinned, row.res);
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        wp   = WP_RST;
        rate = TR_RST;
        ppr  = PPR_RST;
      end else begin
        case ($urandom_range(5))
          0: wp = 1;
          1: wp = 256;
          2: wp = 511;
          3: wp = 0;
          default: wp = $urandom_range(1, 256);
        endcase
        case ($urandom_range(4))
          0: rate = 1;
          1: rate = 16000000;
          2: rate = 24'hFF_FFFF;
          default: rate = $urandom_range(1, 16000000);
        endcase
        case ($urandom_range(5))
          0: ppr = 1;
          1: ppr = 65535;
          2: ppr = 0;
          default: ppr = $urandom_range(1, 65535);
        endcase
      end
      phase_wp = wp;
      // Upper bits of the write data are junk that the register must drop.
      data = $urandom();
      data[WP_W-1:0] = WP_W'(wp);
      write_reg(REG_WRAP_PERIOD, data);
      data = $urandom();
      data[TR_W-1:0] = TR_W'(rate);
      write_reg(REG_TICK_RATE, data);
      data = $urandom();
      data[PPR_W-1:0] = PPR_W'(ppr);
      write_reg(REG_PULSES_PER_REV, data);

      // The final phase runs with both sides flat out.
      if (p == PHASES - 1) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct  = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 50);
        sink_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 50);
      end

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        gap = pick_gap();
        repeat (gap) begin
          offer(OP_TICK, 8'($urandom_range(255)), 1'b0, '0);
          sent++;
        end
        cnt = pick_count();
        offer(OP_EDGE, cnt, 1'b0, '0);
        last_cnt = cnt;
        sent++;
      end
    end

    in_tvalid <= 1'b0;
    settle();
    $display("Run covered %0d input beats (%0d edges) and %0d checked results,",
             n_items, n_edges, results_seen);
    $display("with %0d register writes and one long output hold-off.", n_writes);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== encoder_period_speed_meter.f =====
src/epsm_pkg.sv
src/encoder_period_speed_meter.sv
test/tb.sv
